// ===== rtl/core/oale_pkg.sv =====
package oale_pkg;

    // List capacity and the widths that follow from it.
    localparam int CAPACITY  = 8;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int EXT_W     = CNT_W + 8;
    localparam int RAM_DEPTH = 2 * CAPACITY;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // Command codes carried by an input transfer.
    typedef enum logic [3:0] {
        CMD_INS_FRONT = 4'd0,
        CMD_INS_BACK  = 4'd1,
        CMD_INS_AT    = 4'd2,
        CMD_DEL_FRONT = 4'd3,
        CMD_DEL_BACK  = 4'd4,
        CMD_DEL_AT    = 4'd5,
        CMD_READ_ALL  = 4'd6,
        CMD_SEARCH    = 4'd7,
        CMD_ROTATE    = 4'd8
    } t_cmd;

    // Status codes carried by a result transfer.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

endpackage

// ===== rtl/core/ordered_array_list_engine_top.sv =====
// Insert and delete shift one entry at a time; delete back, every error status and an unused
// command go straight to the result state; search compares one entry at a time; rotate first
// reduces the amount modulo the count in 8 remainder steps, then copies entry by entry; read-all
// gives one result per entry. The single memory sets this pace, and o_stall stays high
// until the last result is registered, so one command runs at a time. Synchronous active-low
// reset empties the list and sets the cursor to -1.
module ordered_array_list_engine_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [3:0]           i_command,
    input  oale_pkg::t_data      i_value,
    input  logic [3:0]           i_position,
    input  logic [7:0]           i_rotate_amount,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_status,
    output oale_pkg::t_data      o_entry_value,
    output logic [3:0]           o_found_position,
    output logic signed [3:0]    o_cursor,
    output logic [3:0]           o_count,
    output logic                 o_last
);

    import oale_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SHIFT_RD = 11'b000_0000_0010,
        S_SHIFT_WR = 11'b000_0000_0100,
        S_RD_ADDR  = 11'b000_0000_1000,
        S_RD_OUT   = 11'b000_0001_0000,
        S_SRCH_RD  = 11'b000_0010_0000,
        S_SRCH_CMP = 11'b000_0100_0000,
        S_MOD      = 11'b000_1000_0000,
        S_ROT_RD   = 11'b001_0000_0000,
        S_ROT_WR   = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_cur_none, n_cur_none;
    logic [IDX_W-1:0]   r_cur_idx, n_cur_idx;
    logic               r_bank, n_bank;
    logic               r_o_valid, n_o_valid;

    // Working registers of the sequencer.
    t_cmd               r_cmd, n_cmd;
    t_data              r_val, n_val;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [7:0]         r_rem, n_rem;
    logic [EXT_W-1:0]   r_div, n_div;
    logic [2:0]         r_step, n_step;
    t_status            r_status, n_status;
    logic [3:0]         r_fpos, n_fpos;

    // Output register.
    logic [2:0]         r_o_status, n_o_status;
    t_data              r_o_entry, n_o_entry;
    logic [3:0]         r_o_fpos, n_o_fpos;
    logic [3:0]         r_o_cursor, n_o_cursor;
    logic [3:0]         r_o_count, n_o_count;
    logic               r_o_last, n_o_last;

    // Memory port.
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_data              wr_data;
    logic [IDX_W-1:0]   rd_idx;
    t_data              rd_data;

    // Extended copies for compares and sums.
    logic [EXT_W-1:0]   cnt_ext, i_ext, i_p1, idx_ext, j_ext, pos_ext, cur_ext;
    logic [EXT_W-1:0]   rem_ext, rem_after, rot_sum, rot_cur;
    logic               is_ins, slot_free, full;

    assign cnt_ext   = EXT_W'(r_count);
    assign i_ext     = EXT_W'(r_i);
    assign i_p1      = i_ext + EXT_W'(1);
    assign idx_ext   = EXT_W'(r_idx);
    assign j_ext     = EXT_W'(r_j);
    assign pos_ext   = EXT_W'(i_position);
    assign cur_ext   = EXT_W'(r_cur_idx);
    assign rem_ext   = EXT_W'(r_rem);
    assign full      = (cnt_ext >= EXT_W'(CAPACITY));
    assign is_ins    = (r_cmd == CMD_INS_FRONT) || (r_cmd == CMD_INS_BACK)
                       || (r_cmd == CMD_INS_AT);
    assign slot_free = !r_o_valid || !i_stall;

    // One restoring step of the rotate amount modulo the count.
    assign rem_after = (rem_ext >= r_div) ? (rem_ext - r_div) : rem_ext;

    // The cursor plus the rotate amount stays below twice the count.
    assign rot_sum = cur_ext + rem_ext;
    assign rot_cur = (rot_sum >= cnt_ext) ? (rot_sum - cnt_ext) : rot_sum;

    oale_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr ({r_bank, rd_idx}),
        .o_rd_data (rd_data)
    );

    // Sequencer and its datapath.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cur_none = r_cur_none;
        n_cur_idx  = r_cur_idx;
        n_bank     = r_bank;
        n_cmd      = r_cmd;
        n_val      = r_val;
        n_idx      = r_idx;
        n_i        = r_i;
        n_j        = r_j;
        n_rem      = r_rem;
        n_div      = r_div;
        n_step     = r_step;
        n_status   = r_status;
        n_fpos     = r_fpos;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_entry  = r_o_entry;
        n_o_fpos   = r_o_fpos;
        n_o_cursor = r_o_cursor;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        wr_en      = 1'b0;
        wr_addr    = {r_bank, r_idx};
        wr_data    = rd_data;
        rd_idx     = r_i[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = t_cmd'(i_command);
                    n_val    = i_value;
                    n_status = ST_OK;
                    n_fpos   = 4'd0;
                    n_state  = S_EMIT;
                    unique case (t_cmd'(i_command))
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (t_cmd'(i_command) == CMD_INS_AT
                                         && (pos_ext == '0
                                             || pos_ext > cnt_ext + EXT_W'(1))) begin
                                n_status = ST_BADPOS;
                            end else begin
                                if (t_cmd'(i_command) == CMD_INS_FRONT) begin
                                    n_idx = '0;
                                end else if (t_cmd'(i_command) == CMD_INS_BACK) begin
                                    n_idx = cnt_ext[IDX_W-1:0];
                                end else begin
                                    n_idx = IDX_W'(pos_ext - EXT_W'(1));
                                end
                                n_i     = r_count;
                                n_state = S_SHIFT_RD;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (t_cmd'(i_command) == CMD_DEL_BACK) begin
                                n_count = r_count - CNT_W'(1);
                                if (cnt_ext == EXT_W'(1)) begin
                                    n_cur_none = 1'b1;
                                end else begin
                                    n_cur_none = 1'b0;
                                    n_cur_idx  = IDX_W'(cnt_ext - EXT_W'(2));
                                end
                            end else if (t_cmd'(i_command) == CMD_DEL_AT
                                         && (pos_ext == '0 || pos_ext > cnt_ext)) begin
                                n_status = ST_BADPOS;
                            end else begin
                                if (t_cmd'(i_command) == CMD_DEL_FRONT) begin
                                    n_idx = '0;
                                    n_i   = '0;
                                end else begin
                                    n_idx = IDX_W'(pos_ext - EXT_W'(1));
                                    n_i   = CNT_W'(pos_ext - EXT_W'(1));
                                end
                                n_state = S_SHIFT_RD;
                            end
                        end
                        CMD_READ_ALL: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_i     = '0;
                                n_state = S_RD_ADDR;
                            end
                        end
                        CMD_SEARCH: begin
                            n_i     = '0;
                            n_state = S_SRCH_RD;
                        end
                        CMD_ROTATE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_rem   = i_rotate_amount;
                                n_div   = cnt_ext << 7;
                                n_step  = 3'd7;
                                n_state = S_MOD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            // Insert walks down opening a gap; delete walks up closing one.
            S_SHIFT_RD: begin
                if (is_ins) begin
                    if (i_ext == idx_ext) begin
                        wr_en      = 1'b1;
                        wr_addr    = {r_bank, r_idx};
                        wr_data    = r_val;
                        n_count    = r_count + CNT_W'(1);
                        n_cur_none = 1'b0;
                        n_cur_idx  = r_idx;
                        n_state    = S_EMIT;
                    end else begin
                        rd_idx  = IDX_W'(i_ext - EXT_W'(1));
                        n_state = S_SHIFT_WR;
                    end
                end else begin
                    if (i_p1 >= cnt_ext) begin
                        n_count    = r_count - CNT_W'(1);
                        n_cur_none = 1'b0;
                        n_cur_idx  = r_idx;
                        n_state    = S_EMIT;
                    end else begin
                        rd_idx  = IDX_W'(i_p1);
                        n_state = S_SHIFT_WR;
                    end
                end
            end

            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = {r_bank, r_i[IDX_W-1:0]};
                wr_data = rd_data;
                n_i     = is_ins ? (r_i - CNT_W'(1)) : (r_i + CNT_W'(1));
                n_state = S_SHIFT_RD;
            end

            S_RD_ADDR: begin
                n_state = S_RD_OUT;
            end

            // Read data stays valid while the address is held.
            S_RD_OUT: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_entry  = rd_data;
                    n_o_fpos   = 4'd0;
                    n_o_cursor = r_cur_none ? 4'hF : cur_ext[3:0];
                    n_o_count  = cnt_ext[3:0];
                    n_o_last   = (i_p1 == cnt_ext);
                    if (i_p1 == cnt_ext) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CNT_W'(1);
                        n_state = S_RD_ADDR;
                    end
                end
            end

            S_SRCH_RD: begin
                if (r_i == r_count) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP: begin
                if (rd_data == r_val) begin
                    n_cur_none = 1'b0;
                    n_cur_idx  = r_i[IDX_W-1:0];
                    n_fpos     = i_p1[3:0];
                    n_state    = S_EMIT;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_SRCH_RD;
                end
            end

            S_MOD: begin
                n_rem  = rem_after[7:0];
                n_div  = r_div >> 1;
                n_step = r_step - 3'd1;
                if (r_step == 3'd0) begin
                    n_i     = '0;
                    n_j     = rem_after[IDX_W-1:0];
                    n_state = S_ROT_RD;
                end
            end

            // Copy into the other bank at the rotated place, then swap banks.
            S_ROT_RD: begin
                if (r_i == r_count) begin
                    n_bank = ~r_bank;
                    if (!r_cur_none) begin
                        n_cur_idx = rot_cur[IDX_W-1:0];
                    end
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ROT_WR;
                end
            end

            S_ROT_WR: begin
                wr_en   = 1'b1;
                wr_addr = {~r_bank, r_j};
                wr_data = rd_data;
                n_i     = r_i + CNT_W'(1);
                n_j     = (j_ext + EXT_W'(1) == cnt_ext) ? '0 : (r_j + IDX_W'(1));
                n_state = S_ROT_RD;
            end

            S_EMIT: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_entry  = '0;
                    n_o_fpos   = r_fpos;
                    n_o_cursor = r_cur_none ? 4'hF : cur_ext[3:0];
                    n_o_count  = cnt_ext[3:0];
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_cur_none <= 1'b1;
            r_cur_idx  <= '0;
            r_bank     <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cur_none <= n_cur_none;
            r_cur_idx  <= n_cur_idx;
            r_bank     <= n_bank;
            r_o_valid  <= n_o_valid;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_i        <= n_i;
        r_j        <= n_j;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_step     <= n_step;
        r_status   <= n_status;
        r_fpos     <= n_fpos;
        r_o_status <= n_o_status;
        r_o_entry  <= n_o_entry;
        r_o_fpos   <= n_o_fpos;
        r_o_cursor <= n_o_cursor;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_entry_value    = r_o_entry;
    assign o_found_position = r_o_fpos;
    assign o_cursor         = r_o_cursor;
    assign o_count          = r_o_count;
    assign o_last           = r_o_last;

    // The count never passes the capacity.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A live cursor never points past the count.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cur_none |-> (cur_ext <= cnt_ext))
        else $error("cursor beyond count");

    // Every accepted command starts work.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("command accepted without work");

    // Only read-all produces a result that is not the last one.
    a_multi_readall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_cmd == CMD_READ_ALL))
        else $error("non-final result outside read-all");

    // Rotation destinations stay inside the list.
    a_rot_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT_WR) |-> (j_ext < cnt_ext))
        else $error("rotate destination out of range");

endmodule

// ===== rtl/core/oale_ram.sv =====
module oale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== bench/ordered_array_list_engine_top_tb.sv =====
`timescale 1ns / 100ps

module ordered_array_list_engine_top_tb;
    import oale_pkg::*;

    localparam int NO_TRANSFER_LIMIT    = 2000;
    localparam int RECEIVER_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES        = 40;
    localparam int RANDOM_ITEMS         = 115;
    localparam int CALM_START           = 35;
    localparam int CALM_END             = 75;
    localparam int DRAIN_PAUSE_AT       = 90;
    localparam int IDLE_PCT             = 17;
    localparam int MAX_PRINTED          = 40;
    localparam int NUM_STATUS           = 5;

    localparam logic [3:0] LAST_UNUSED_CMD = 4'd15;
    localparam t_data      DATA_MIN        = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_data      DATA_MAX        = {1'b0, {(DATA_W-1){1'b1}}};

    // One result transfer as the list engine should produce it.
    typedef struct packed {
        logic [2:0]  status;
        t_data       entry_value;
        logic [3:0]  found_position;
        logic [3:0]  cursor;
        logic [3:0]  count;
        logic        last;
    } t_list_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_command;
    t_data       i_value;
    logic [3:0]  i_position;
    logic [7:0]  i_rotate_amount;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    t_data       o_entry_value;
    logic [3:0]  o_found_position;
    logic signed [3:0] o_cursor;
    logic [3:0]  o_count;
    logic        o_last;

    // Predicted list contents, count and cursor.
    t_data         list_mem [CAPACITY];
    int            list_len;
    int            cursor_idx;
    t_list_result  pending_results [$];

    int mismatch_count = 0;
    int commands_sent  = 0;
    int results_seen   = 0;
    int status_hits [NUM_STATUS];

    // Idling controls for the sender and the receiver.
    int sender_idle_pct = IDLE_PCT;
    int stall_pct       = IDLE_PCT;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    ordered_array_list_engine_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_value          (i_value),
        .i_position       (i_position),
        .i_rotate_amount  (i_rotate_amount),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_entry_value    (o_entry_value),
        .o_found_position (o_found_position),
        .o_cursor         (o_cursor),
        .o_count          (o_count),
        .o_last           (o_last)
    );

    // Free-running 2 ns clock.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Queue one expected result, tagged with the current count and cursor.
    function automatic void push_result(input logic [2:0] status, input t_data entry,
                                        input int fpos, input logic is_last);
        t_list_result r;
        r.status         = status;
        r.entry_value    = entry;
        r.found_position = 4'(fpos);
        r.cursor         = 4'(cursor_idx);
        r.count          = 4'(list_len);
        r.last           = is_last;
        pending_results.push_back(r);
        status_hits[status]++;
    endfunction

    function automatic void clear_list_model();
        foreach (list_mem[i]) list_mem[i] = '0;
        list_len   = 0;
        cursor_idx = -1;
    endfunction

    // Update the predicted list for one accepted command and queue its results.
    function automatic void apply_list_command(input logic [3:0] cmd, input t_data val,
                                               input logic [3:0] pos, input logic [7:0] amt);
        t_data rotated [CAPACITY];
        int    p;
        int    slot;
        int    shift;
        int    i;
        p = pos;
        case (cmd)
            CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                if (list_len >= CAPACITY) begin
                    push_result(ST_FULL, '0, 0, 1'b1);
                end else if (cmd == CMD_INS_AT && (p < 1 || p > list_len + 1)) begin
                    push_result(ST_BADPOS, '0, 0, 1'b1);
                end else begin
                    slot = (cmd == CMD_INS_FRONT) ? 0 : (cmd == CMD_INS_BACK) ? list_len : p - 1;
                    for (i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
                    list_mem[slot] = val;
                    list_len++;
                    cursor_idx = slot;
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                if (list_len == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else if (cmd == CMD_DEL_AT && (p < 1 || p > list_len)) begin
                    push_result(ST_BADPOS, '0, 0, 1'b1);
                end else begin
                    slot = (cmd == CMD_DEL_FRONT) ? 0 :
                           (cmd == CMD_DEL_BACK) ? list_len - 1 : p - 1;
                    for (i = slot; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                    cursor_idx = (cmd == CMD_DEL_FRONT) ? 0 :
                                 (cmd == CMD_DEL_BACK) ? list_len - 1 : p - 1;
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            CMD_READ_ALL: begin
                if (list_len == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < list_len; i++)
                        push_result(ST_OK, list_mem[i], 0, i == list_len - 1);
                end
            end
            CMD_SEARCH: begin
                slot = -1;
                for (i = 0; i < list_len && slot < 0; i++)
                    if (list_mem[i] === val) slot = i;
                if (slot >= 0) begin
                    cursor_idx = slot;
                    push_result(ST_OK, '0, slot + 1, 1'b1);
                end else begin
                    push_result(ST_NOTFOUND, '0, 0, 1'b1);
                end
            end
            CMD_ROTATE: begin
                if (list_len == 0) begin
                    push_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    shift = int'(amt) % list_len;
                    for (i = 0; i < list_len; i++) rotated[(i + shift) % list_len] = list_mem[i];
                    for (i = 0; i < list_len; i++) list_mem[i] = rotated[i];
                    if (cursor_idx >= 0) cursor_idx = (cursor_idx + shift) % list_len;
                    push_result(ST_OK, '0, 0, 1'b1);
                end
            end
            // Unused command codes leave everything as it is.
            default: push_result(ST_OK, '0, 0, 1'b1);
        endcase
    endfunction

    // Mix of extremes, small values that repeat, and wide random values.
    function automatic t_data pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return DATA_MIN;
        if (r < 20) return DATA_MAX;
        if (r < 25) return '0;
        if (r < 30) return -1;
        if (r < 60) return t_data'($urandom_range(7, 0));
        return t_data'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Send one command; called at a falling edge, returns at the falling edge after it is accepted.
    task automatic send_command(input logic [3:0] cmd, input t_data val,
                                input logic [3:0] pos = 4'd0, input logic [7:0] amt = 8'd0);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command       = cmd;
        i_value         = val;
        i_position      = pos;
        i_rotate_amount = amt;
        i_valid         = 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_list_command(cmd, val, pos, amt);
        commands_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Every command but the inserts on a freshly reset, empty list, plus bad insert positions.
    task automatic test_empty_list();
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_BACK, '0);
        send_command(CMD_DEL_AT, '0, 4'd1);
        send_command(CMD_READ_ALL, '0);
        send_command(CMD_ROTATE, '0, 4'd0, 8'd3);
        send_command(CMD_SEARCH, '0);
        send_command(LAST_UNUSED_CMD, DATA_MAX, 4'd15, 8'd255);
        send_command(CMD_INS_AT, 5, 4'd0);
        send_command(CMD_INS_AT, 5, 4'd2);
        wait_for_results();
    endtask

    // Fill to capacity, starting with extreme values, then exercise full-list and edge cases.
    task automatic test_fill_and_edges();
        send_command(CMD_INS_FRONT, DATA_MIN);
        send_command(CMD_INS_BACK, DATA_MAX);
        send_command(CMD_INS_AT, '0, 4'd2);
        send_command(CMD_INS_AT, -1, 4'd4);
        while (list_len < CAPACITY) send_command(CMD_INS_BACK, t_data'($urandom));
        send_command(CMD_INS_AT, 5, 4'd1);
        send_command(CMD_READ_ALL, '0);
        send_command(CMD_SEARCH, DATA_MAX);
        send_command(CMD_SEARCH, -2);
        send_command(CMD_ROTATE, '0, 4'd0, 8'd255);
        send_command(CMD_ROTATE, '0, 4'd0, 8'd0);
        send_command(CMD_DEL_AT, '0, 4'd0);
        send_command(CMD_DEL_AT, '0, 4'd15);
        send_command(CMD_DEL_AT, '0, 4'(list_len));
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_BACK, '0);
        send_command(CMD_READ_ALL, '0);
        wait_for_results();
    endtask

    // Mostly sensible commands with random content, some noise and bad positions.
    task automatic test_random_traffic();
        int unsigned pick;
        logic [3:0]  cmd;
        t_data       val;
        logic [3:0]  pos;
        logic [7:0]  amt;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // A calm stretch in the middle where neither side idles.
            if (n == CALM_START) begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            if (n == CALM_END) begin
                sender_idle_pct = IDLE_PCT;
                stall_pct       = IDLE_PCT;
            end
            // The sender pauses once until the engine has answered everything.
            if (n == DRAIN_PAUSE_AT) wait_for_results();
            pick = $urandom_range(99);
            val  = pick_value();
            pos  = 4'($urandom_range(15, 0));
            amt  = 8'($urandom_range(255, 0));
            if (pick < 33) begin
                cmd = 4'($urandom_range(CMD_INS_AT, CMD_INS_FRONT));
                if (cmd == CMD_INS_AT && $urandom_range(99) < 85)
                    pos = 4'($urandom_range(list_len + 1, 1));
            end else if (pick < 63) begin
                cmd = 4'($urandom_range(CMD_DEL_AT, CMD_DEL_FRONT));
                if (cmd == CMD_DEL_AT && list_len > 0 && $urandom_range(99) < 85)
                    pos = 4'($urandom_range(list_len, 1));
            end else if (pick < 73) begin
                cmd = CMD_READ_ALL;
            end else if (pick < 85) begin
                cmd = CMD_SEARCH;
                if (list_len > 0 && $urandom_range(99) < 60)
                    val = list_mem[$urandom_range(list_len - 1, 0)];
            end else if (pick < 93) begin
                cmd = CMD_ROTATE;
            end else begin
                cmd = 4'($urandom_range(15, 0));
                val = t_data'($urandom);
            end
            send_command(cmd, val, pos, amt);
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while commands keep coming.
    task automatic test_output_backpressure();
        if (list_len < 2) begin
            send_command(CMD_INS_BACK, pick_value());
            send_command(CMD_INS_BACK, pick_value());
        end
        hold_requests++;
        send_command(CMD_READ_ALL, '0);
        send_command(CMD_INS_FRONT, pick_value());
        send_command(CMD_READ_ALL, '0);
        send_command(CMD_ROTATE, '0, 4'd0, 8'($urandom_range(255, 0)));
        send_command(CMD_READ_ALL, '0);
        wait_for_results();
    endtask

    // Receiver: random stalls, or a long hold when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = RECEIVER_HOLD_CYCLES - 1;
            i_stall     = 1'b1;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with no result expected");
            end else begin
                want = pending_results.pop_front();
                check_field("status", o_status, want.status);
                check_field("entry_value", o_entry_value, want.entry_value);
                check_field("found_position", o_found_position, want.found_position);
                check_field("cursor", $unsigned(o_cursor), want.cursor);
                check_field("count", o_count, want.count);
                check_field("last", o_last, want.last);
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= NO_TRANSFER_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                         NO_TRANSFER_LIMIT, pending_results.size());
                $display("ordered_array_list_engine_top_tb failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_command       = CMD_INS_FRONT;
        i_value         = '0;
        i_position      = '0;
        i_rotate_amount = '0;
        foreach (status_hits[s]) status_hits[s] = 0;
        clear_list_model();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_fill_and_edges();
        test_random_traffic();
        test_output_backpressure();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("Ran %0d commands and checked %0d results (%0d mismatches).",
                 commands_sent, results_seen, mismatch_count);
        $display("Status mix: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d.",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_BADPOS], status_hits[ST_NOTFOUND]);
        if (mismatch_count == 0) begin
            $display("ordered_array_list_engine_top_tb passed");
        end else begin
            $display("ordered_array_list_engine_top_tb failed");
        end
        $finish;
    end

endmodule
